@@ rtl/ppss_pkg.sv @@
// ppss_pkg: shared types, constants and helpers of the paletted section store
// used by ppss_ctrl, ppss_dp and the top level; depends on nothing else
`default_nettype none

package ppss_pkg;

  localparam int ID_W   = 16;
  localparam int IDX_W  = 8;
  localparam int BPE_W  = 4;
  localparam int POS_W  = 4;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 24;

  // indices per 64-bit word for each bits-per-entry value (1 to 8 used)
  typedef logic [6:0] per_t;
  localparam per_t PER_OF [16] = '{
    7'd64, 7'd64, 7'd32, 7'd21, 7'd16, 7'd12, 7'd10, 7'd9,
    7'd8,  7'd8,  7'd8,  7'd8,  7'd8,  7'd8,  7'd8,  7'd8
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_IDX_RD, ST_IDX_W, ST_PAL_W, ST_CLEAR, ST_CLEAR_END,
    ST_SEARCH, ST_SEARCH_W, ST_MISS, ST_GROW, ST_ZERO, ST_SET, ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MOD, OP_IDX_RD, OP_PAL_RD_IDX, OP_OLD, OP_CLEAR,
    OP_CLEAR_END, OP_SEARCH_RD, OP_SEARCH_CMP, OP_FULL, OP_APPEND, OP_GROW,
    OP_ZERO, OP_SET, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic is_write;
    logic indirect;
    logic clear_last;
    logic search_end;
    logic match;
    logic pal_full;
    logic bpe_change;
    logic zero_done;
    logic out_free;
  } dp_stat_t;

  // bit width of the palette count, clamped to 1..8
  function automatic logic [BPE_W-1:0] bpe_for(input logic [IDX_W-1:0] count);
    logic [BPE_W-1:0] w;
    w = 4'd1;
    for (int i = 0; i < IDX_W; i++) begin
      if (count[i]) w = BPE_W'(i + 1);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/paletted_packed_section_store.sv @@
// paletted_packed_section_store: top level, joins sequencer and datapath
// depends on ppss_pkg, ppss_ctrl, ppss_dp
`default_nettype none

// Stores one 16x16x16 section of 16-bit ids, either as the single id
// initial_block_id or as palette indices of a variable bits per entry, with
// as many entries as fit whole into WORD_COUNT 64-bit words. One item is in
// work at a time; its result waits in an output register, so the next item
// can be taken while the result stalls. A read reduces the entry number, then
// reads the index store and the palette. A write adds a palette search over
// the entries in use (up to PALETTE_DEPTH), then appends the id on a miss and
// stores the index. The first write of a single-mode section adds a clearing
// pass over the index store, and a write that widens the bits per entry zeroes
// every entry that no longer fits in the packed words. The user writes
// configuration through cfg_we and cfg_wdata only while the block is idle;
// the block itself does not enforce this.
module paletted_packed_section_store #(
  parameter int SECTION_ENTRIES = 4096,
  parameter int PALETTE_DEPTH   = 255,
  parameter int WORD_COUNT      = 512
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire  [ppss_pkg::ID_W-1:0]  cfg_wdata,  // initial_block_id
  input  wire                        s_tvalid,
  output logic                       s_tready,
  input  wire  [ppss_pkg::IN_W-1:0]  s_tdata,    // pos_x, pos_y, pos_z, new_id
  input  wire  [0:0]                 s_tuser,    // operation
  output logic                       m_tvalid,
  input  wire                        m_tready,
  output logic [ppss_pkg::OUT_W-1:0] m_tdata     // old_id, status
);
  import ppss_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ppss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  ppss_dp #(
    .SECTION_ENTRIES (SECTION_ENTRIES),
    .PALETTE_DEPTH   (PALETTE_DEPTH),
    .WORD_COUNT      (WORD_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

@@ rtl/ppss_ctrl.sv @@
// ppss_ctrl: sequencer of the section store, issues at most one datapath op per cycle
// depends on ppss_pkg
`default_nettype none

module ppss_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  ppss_pkg::dp_stat_t stat,
  output ppss_pkg::dp_cmd_t  cmd
);
  import ppss_pkg::*;

  ctl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and op select
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.op     = OP_LOAD;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (stat.mod_done) state_next = ST_IDX_RD;
        else cmd.op = OP_MOD;
      end
      ST_IDX_RD: begin
        cmd.op     = OP_IDX_RD;
        state_next = ST_IDX_W;
      end
      ST_IDX_W: begin
        cmd.op     = OP_PAL_RD_IDX;
        state_next = ST_PAL_W;
      end
      ST_PAL_W: begin
        cmd.op = OP_OLD;
        if (!stat.is_write)      state_next = ST_DONE;
        else if (!stat.indirect) state_next = ST_CLEAR;
        else                     state_next = ST_SEARCH;
      end
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) state_next = ST_CLEAR_END;
      end
      ST_CLEAR_END: begin
        cmd.op     = OP_CLEAR_END;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (stat.search_end) begin
          state_next = ST_MISS;
        end else begin
          cmd.op     = OP_SEARCH_RD;
          state_next = ST_SEARCH_W;
        end
      end
      ST_SEARCH_W: begin
        cmd.op = OP_SEARCH_CMP;
        if (stat.match) state_next = ST_SET;
        else            state_next = ST_SEARCH;
      end
      ST_MISS: begin
        if (stat.pal_full) begin
          cmd.op     = OP_FULL;
          state_next = ST_DONE;
        end else begin
          cmd.op     = OP_APPEND;
          state_next = ST_GROW;
        end
      end
      ST_GROW: begin
        cmd.op = OP_GROW;
        if (stat.bpe_change) state_next = ST_ZERO;
        else                 state_next = ST_SET;
      end
      ST_ZERO: begin
        if (stat.zero_done) state_next = ST_SET;
        else cmd.op = OP_ZERO;
      end
      ST_SET: begin
        cmd.op     = OP_SET;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ppss_dp.sv @@
// ppss_dp: datapath of the section store: registers, palette and index stores
// depends on ppss_pkg; driven by ops from ppss_ctrl
`default_nettype none

module ppss_dp #(
  parameter int SECTION_ENTRIES = 4096,
  parameter int PALETTE_DEPTH   = 255,
  parameter int WORD_COUNT      = 512
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire  [ppss_pkg::ID_W-1:0]  cfg_wdata,
  input  wire  [ppss_pkg::IN_W-1:0]  s_tdata,
  input  wire  [0:0]                 s_tuser,
  input  wire                        m_tready,
  output logic                       m_tvalid,
  output logic [ppss_pkg::OUT_W-1:0] m_tdata,
  input  ppss_pkg::dp_cmd_t           cmd,
  output ppss_pkg::dp_stat_t          stat
);
  import ppss_pkg::*;

  localparam int EW = $clog2(SECTION_ENTRIES);
  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(((SECTION_ENTRIES > 255) ? SECTION_ENTRIES : 255) + 1);
  localparam int LW = $clog2(WORD_COUNT * 64 + 1);
  localparam int RW = 3 * POS_W;
  localparam logic [RW:0]   N_EXT = (RW + 1)'(SECTION_ENTRIES);
  localparam logic [LW-1:0] N_LIM = LW'(SECTION_ENTRIES);

  // entries that fit in the packed words at a given bits per entry
  function automatic logic [LW-1:0] limit_of(input logic [BPE_W-1:0] b);
    return LW'(WORD_COUNT) * LW'(PER_OF[b]);
  endfunction

  // control registers
  logic [ID_W-1:0]  init_id;
  logic             indirect;
  logic [BPE_W-1:0] bpe;
  logic [IDX_W-1:0] pal_count;

  // item and work registers
  logic             is_write;
  logic [RW-1:0]    entry;
  logic [ID_W-1:0]  nid;
  logic [IDX_W-1:0] slot;
  logic             oob;
  logic [ID_W-1:0]  old_id;
  logic             status;
  logic [CW-1:0]    cnt;

  // stores
  logic [IDX_W-1:0] idx_mem [SECTION_ENTRIES];
  logic [ID_W-1:0]  pal_mem [PALETTE_DEPTH];
  logic [IDX_W-1:0] idx_rdata;
  logic [ID_W-1:0]  pal_rdata;

  logic             in_cap;
  logic [IDX_W-1:0] idx_eff;
  logic [BPE_W-1:0] nb;
  logic [LW-1:0]    nb_lim;
  logic             idx_we;
  logic [EW-1:0]    idx_waddr;
  logic [IDX_W-1:0] idx_wdata;
  logic             pal_we;
  logic [PW-1:0]    pal_waddr;
  logic [ID_W-1:0]  pal_wdata;
  logic             pal_re;
  logic [PW-1:0]    pal_raddr;

  // derived values
  assign in_cap  = LW'(entry) < limit_of(bpe);
  assign idx_eff = in_cap ? idx_rdata : '0;
  assign nb      = bpe_for(pal_count);
  assign nb_lim  = limit_of(nb);

  // status to the sequencer
  always_comb begin
    stat.mod_done   = {1'b0, entry} < N_EXT;
    stat.is_write   = is_write;
    stat.indirect   = indirect;
    stat.clear_last = cnt == CW'(SECTION_ENTRIES - 1);
    stat.search_end = cnt >= CW'(pal_count);
    stat.match      = pal_rdata == nid;
    stat.pal_full   = pal_count >= IDX_W'(PALETTE_DEPTH);
    stat.bpe_change = nb != bpe;
    stat.zero_done  = cnt >= CW'(SECTION_ENTRIES);
    stat.out_free   = !m_tvalid || m_tready;
  end

  // store port muxes
  always_comb begin
    idx_we    = 1'b0;
    idx_waddr = cnt[EW-1:0];
    idx_wdata = '0;
    pal_we    = 1'b0;
    pal_waddr = '0;
    pal_wdata = init_id;
    pal_re    = 1'b0;
    pal_raddr = cnt[PW-1:0];
    case (cmd.op)
      OP_CLEAR, OP_ZERO: idx_we = 1'b1;
      OP_SET: begin
        idx_we    = in_cap;
        idx_waddr = entry[EW-1:0];
        idx_wdata = slot;
      end
      OP_CLEAR_END: pal_we = 1'b1;
      OP_APPEND: begin
        pal_we    = 1'b1;
        pal_waddr = pal_count[PW-1:0];
        pal_wdata = nid;
      end
      OP_PAL_RD_IDX: begin
        pal_re    = 1'b1;
        pal_raddr = idx_eff[PW-1:0];
      end
      OP_SEARCH_RD: pal_re = 1'b1;
      default: ;
    endcase
  end

  // index store
  always_ff @(posedge clk) begin
    if (idx_we) idx_mem[idx_waddr] <= idx_wdata;
    if (cmd.op == OP_IDX_RD) idx_rdata <= idx_mem[entry[EW-1:0]];
  end

  // palette store
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
    if (pal_re) pal_rdata <= pal_mem[pal_raddr];
  end

  // control registers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      init_id   <= '0;
      indirect  <= 1'b0;
      bpe       <= BPE_W'(1);
      pal_count <= IDX_W'(1);
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) init_id <= cfg_wdata;
      case (cmd.op)
        OP_CLEAR_END: begin
          indirect <= 1'b1;
          bpe      <= BPE_W'(1);
        end
        OP_APPEND: pal_count <= pal_count + IDX_W'(1);
        OP_GROW:   if (nb != bpe) bpe <= nb;
        default: ;
      endcase
      if (cmd.op == OP_OUT) m_tvalid <= 1'b1;
      else if (m_tready)    m_tvalid <= 1'b0;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_write <= s_tuser[0];
        // entry = y*256 + z*16 + x
        entry    <= {s_tdata[7:4], s_tdata[11:8], s_tdata[3:0]};
        nid      <= s_tdata[27:12];
      end
      OP_MOD: entry <= entry - RW'(SECTION_ENTRIES);
      OP_PAL_RD_IDX: begin
        oob <= (idx_eff >= pal_count) || (idx_eff >= IDX_W'(PALETTE_DEPTH));
      end
      OP_OLD: begin
        old_id <= indirect ? (oob ? '0 : pal_rdata) : init_id;
        status <= 1'b0;
        cnt    <= '0;
      end
      OP_CLEAR, OP_ZERO: cnt <= cnt + CW'(1);
      OP_CLEAR_END: cnt <= '0;
      OP_SEARCH_CMP: begin
        if (pal_rdata == nid) slot <= cnt[IDX_W-1:0];
        else                  cnt  <= cnt + CW'(1);
      end
      OP_FULL:   status <= 1'b1;
      OP_APPEND: slot   <= pal_count;
      // sweep zeroes entries that no longer fit in the packed words
      OP_GROW:   cnt <= (nb_lim >= N_LIM) ? CW'(SECTION_ENTRIES) : CW'(nb_lim);
      OP_OUT:    m_tdata <= {7'b0, status, old_id};
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ppss_checker.sv @@
// ppss_checker: port-level assertions on the section store
// depends on ppss_pkg; bound to paletted_packed_section_store
`default_nettype none

module ppss_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        s_tvalid,
  input wire                        s_tready,
  input wire                        m_tvalid,
  input wire                        m_tready,
  input wire [ppss_pkg::OUT_W-1:0]  m_tdata
);
  import ppss_pkg::*;

  // no result pending right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time: input closes after a beat
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input open right after a beat");

  // a result appears only at the end of an item's work
  a_result_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without item in work");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind paletted_packed_section_store ppss_checker u_ppss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for paletted_packed_section_store
// depends on ppss_pkg (port widths) and the rtl under test; needs no files
`timescale 1ns / 100ps

module tb;

  localparam bit SEC_RD = 1'b0;
  localparam bit SEC_WR = 1'b1;
  localparam int PAL_DEPTH = 255;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    bit        op;
    bit [3:0]  x;
    bit [3:0]  y;
    bit [3:0]  z;
    bit [15:0] id;
  } access_t;

  typedef struct {
    bit [15:0] old_id;
    bit        status;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ppss_pkg::ID_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  wire  s_tready;
  logic [ppss_pkg::IN_W-1:0] s_tdata = '0;   // pos_x, pos_y, pos_z, new_id
  logic [0:0] s_tuser = '0;                  // operation
  wire  m_tvalid;
  logic m_tready = 1'b0;
  wire  [ppss_pkg::OUT_W-1:0] m_tdata;       // old_id, status

  paletted_packed_section_store uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // section shadow: mode, palette and one palette index per entry
  bit        sec_indirect;
  int        pal_count;
  bit [15:0] pal_ids [PAL_DEPTH];
  bit [7:0]  entry_idx [4096];
  bit [15:0] block_id_reg;

  access_t pending_q[$];
  lookup_t lookup_q[$];
  int      errors;
  bit      tx_calm, rx_calm, tx_pause;
  int      hold_asks, hold_done;
  bit [15:0] id_pool [12];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // expected old id and status for one accepted beat, updating the shadow
  function automatic void predict_access(input access_t a);
    lookup_t r;
    int e, slot;
    bit found;
    e = int'({a.y, a.z, a.x});
    r.old_id = sec_indirect ? pal_ids[entry_idx[e]] : pal_ids[0];
    r.status = 1'b0;
    if (a.op == SEC_WR) begin
      if (!sec_indirect) begin
        sec_indirect = 1'b1;
        foreach (entry_idx[i]) entry_idx[i] = '0;
      end
      found = 1'b0;
      slot = 0;
      for (int i = 0; i < pal_count; i++) begin
        if (!found && pal_ids[i] == a.id) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (!found) begin
        if (pal_count >= PAL_DEPTH) r.status = 1'b1;
        else begin
          slot = pal_count;
          pal_ids[slot] = a.id;
          pal_count++;
        end
      end
      if (!r.status) entry_idx[e] = slot[7:0];
    end
    lookup_q = {lookup_q, r};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // driver: one beat in flight, random gap after each unless tx_calm is set
  int tx_gap;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) predict_access(pending_q.pop_front());
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() > 0 && !tx_pause) begin
          s_tvalid <= 1'b1;
          s_tuser  <= pending_q[0].op;
          s_tdata  <= {4'b0, pending_q[0].id, pending_q[0].z, pending_q[0].y,
                       pending_q[0].x};
          tx_gap = tx_calm ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, long hold on request, field checks
  int hold_cnt;
  always @(posedge clk) begin
    lookup_t w;
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (lookup_q.size() == 0) begin
          $display("unexpected result beat %0h", m_tdata);
          errors++;
        end else begin
          w = lookup_q.pop_front();
          if (m_tdata[15:0] != w.old_id)
            report("old_id", int'(m_tdata[15:0]), int'(w.old_id));
          if (m_tdata[16] != w.status)
            report("status", int'(m_tdata[16]), int'(w.status));
        end
      end
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (rx_calm) m_tready <= 1'b1;
      else m_tready <= (pick_gap() == 0);
    end
  end

  // watchdog on cycles without progress
  int quiet;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (pending_q.size() == 0 && lookup_q.size() == 0))
      quiet = 0;
    else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push(input bit op, input int x, input int y, input int z,
                      input int id);
    access_t a;
    a.op = op; a.x = x[3:0]; a.y = y[3:0]; a.z = z[3:0]; a.id = id[15:0];
    pending_q = {pending_q, a};
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || lookup_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_block_id(input bit [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    block_id_reg = v;
    if (!sec_indirect) pal_ids[0] = v;
  endtask

  task automatic random_burst(input int n, input int rand_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      push(r < 40 ? SEC_RD : SEC_WR, $urandom_range(0, 15), $urandom_range(0, 15),
           $urandom_range(0, 15),
           ($urandom_range(0, 99) < rand_pct) ? $urandom_range(0, 65535)
                                               : id_pool[$urandom_range(0, 11)]);
    end
  endtask

  initial begin
    sec_indirect = 1'b0;
    pal_count = 1;
    block_id_reg = '0;
    foreach (pal_ids[i]) pal_ids[i] = '0;
    foreach (entry_idx[i]) entry_idx[i] = '0;
    errors = 0;
    tx_calm = 1'b0; rx_calm = 1'b0; tx_pause = 1'b0;
    hold_asks = 0; hold_done = 0;
    id_pool[0] = 16'h0000; id_pool[1] = 16'hFFFF; id_pool[2] = 16'h8000;
    id_pool[3] = 16'h0001;
    for (int i = 4; i < 12; i++) id_pool[i] = 16'($urandom_range(0, 65535));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // single mode: register extremes, reads see the register
    write_block_id(16'hFFFF);
    push(SEC_RD, 0, 0, 0, 16'h1234);
    push(SEC_RD, 15, 15, 15, 16'hFFFF);
    drain();
    write_block_id(16'h0000);
    write_block_id(16'hA5C3);
    push(SEC_RD, 15, 0, 15, 0);
    // same id as the register still turns the section indirect
    push(SEC_WR, 15, 15, 15, 16'hA5C3);
    push(SEC_RD, 15, 15, 15, 0);
    push(SEC_RD, 0, 0, 0, 0);
    drain();
    // indirect mode: register write leaves the palette alone
    write_block_id(16'hFFFF);
    push(SEC_RD, 3, 9, 12, 0);
    push(SEC_WR, 0, 0, 0, 16'hFFFF);
    push(SEC_WR, 15, 0, 0, 16'h0000);
    push(SEC_WR, 0, 15, 0, 16'h8000);
    push(SEC_WR, 0, 0, 15, 16'h7FFF);
    push(SEC_WR, 15, 0, 0, 16'hFFFF);
    push(SEC_RD, 0, 0, 0, 0);
    push(SEC_RD, 15, 0, 0, 0);
    push(SEC_RD, 0, 15, 0, 0);
    push(SEC_RD, 0, 0, 15, 0);
    push(SEC_RD, 15, 15, 15, 0);
    push(SEC_WR, 7, 7, 7, 16'h0001);
    push(SEC_RD, 7, 7, 7, 0);
    drain();
    write_block_id(16'h0000);

    // random traffic over a small id set, with a long receiver hold
    random_burst(60, 15);
    hold_asks++;
    drain();
    write_block_id(16'($urandom_range(0, 65535)));
    tx_calm = 1'b1; rx_calm = 1'b1;
    random_burst(30, 15);
    drain();
    tx_calm = 1'b0; rx_calm = 1'b0;
    random_burst(50, 10);
    drain();

    // fresh ids: the palette fills and further new ids are dropped
    for (int i = 0; i < 250; i++)
      push(SEC_WR, $urandom_range(0, 15), $urandom_range(0, 15),
           $urandom_range(0, 15), $urandom_range(0, 65535));
    drain();
    random_burst(40, 30);
    drain();

    if (errors == 0 && lookup_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ppss_pkg.sv
rtl/ppss_ctrl.sv
rtl/ppss_dp.sv
rtl/paletted_packed_section_store.sv
rtl/ppss_checker.sv
bench/tb.sv
